// ----- src/rar_pkg.sv -----
// Shared constants and codes for the ring all-reduce schedule generator.
package rar_pkg;

    localparam int MAX_RANKS_DEF = 16;

    localparam int BYTES_W  = 40;
    localparam int RANKS_W  = 5;
    localparam int RANK_W   = 4;
    localparam int EBYTES_W = 4;
    localparam int STEP_W   = 4;
    localparam int OPIDX_W  = 7;
    localparam int PAIR_W   = 5;
    localparam int CFGIDX_W = 2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CFG  = 2'd1;
    localparam logic [1:0] STATUS_BAD_STEP = 2'd2;

    localparam logic [1:0] OP_PUT         = 2'd0;
    localparam logic [1:0] OP_RECV        = 2'd1;
    localparam logic [1:0] OP_RECV_REDUCE = 2'd2;

    localparam logic [CFGIDX_W-1:0] REG_RANK_COUNT    = 2'd0;
    localparam logic [CFGIDX_W-1:0] REG_OWN_RANK      = 2'd1;
    localparam logic [CFGIDX_W-1:0] REG_TENSOR_BYTES  = 2'd2;
    localparam logic [CFGIDX_W-1:0] REG_ELEMENT_BYTES = 2'd3;

    localparam logic [RANKS_W-1:0]  RANK_COUNT_RST    = 5'd2;
    localparam logic [EBYTES_W-1:0] ELEMENT_BYTES_RST = 4'd4;

endpackage

// ----- src/rar_div.sv -----
// Restoring bit-serial divider: one quotient bit per cycle.
module rar_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rar_pkg::BYTES_W-1:0]   dividend,
    input  logic [rar_pkg::RANKS_W-1:0]   divisor,
    output logic                          busy,
    output logic [rar_pkg::BYTES_W-1:0]   quotient,
    output logic [rar_pkg::RANKS_W-1:0]   remainder
);
    import rar_pkg::*;

    localparam int CNT_W = $clog2(BYTES_W + 1);

    logic [BYTES_W-1:0] quo_reg;
    logic [RANKS_W-1:0] rem_reg;
    logic [RANKS_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RANKS_W:0]   trial;
    logic [RANKS_W:0]   diff;

    assign trial = {rem_reg, quo_reg[BYTES_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(BYTES_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= diff[RANKS_W-1:0];
                quo_reg <= {quo_reg[BYTES_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[RANKS_W-1:0];
                quo_reg <= {quo_reg[BYTES_W-2:0], 1'b0};
            end
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ----- src/ring_allreduce_schedule_gen.sv -----
// Ring all-reduce schedule generator: per-step Put, Recv and RecvReduce descriptors.
// A valid request passes the check, the shard divider and two multiply slots before its
// first result; an error report follows the check directly. Only one request at a time:
// a new one is taken in idle, after the last is done; an output stall holds the results.
// Reset: asynchronous active-low; configuration registers go to their defaults, the op
// counter and the shard readiness marks are cleared.
module ring_allreduce_schedule_gen #(
    parameter int MAX_RANKS = rar_pkg::MAX_RANKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rar_pkg::CFGIDX_W-1:0]   cfg_index,
    input  logic [rar_pkg::BYTES_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           phase,
    input  logic [rar_pkg::STEP_W-1:0]     step_num,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [1:0]                     op_kind,
    output logic [rar_pkg::OPIDX_W-1:0]    op_index,
    output logic [rar_pkg::BYTES_W-1:0]    byte_count,
    output logic [rar_pkg::BYTES_W-1:0]    byte_offset,
    output logic [rar_pkg::RANK_W-1:0]     peer_rank,
    output logic                           dep_valid,
    output logic [rar_pkg::OPIDX_W-1:0]    dep_index,
    output logic [rar_pkg::PAIR_W-1:0]     pair_id,
    output logic                           last
);
    import rar_pkg::*;

    localparam int IDX_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;

    // The sequencer walks one request through validation, the shard split,
    // the two offset products, and then up to three result slots, or an error slot.
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV_WAIT, S_MUL_SEND, S_MUL_RECV,
        S_PUT, S_RECV, S_REDUCE, S_ERR
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [RANKS_W-1:0]  rank_count_reg;
    logic [RANK_W-1:0]   own_rank_reg;
    logic [BYTES_W-1:0]  tensor_bytes_reg;
    logic [EBYTES_W-1:0] element_bytes_reg;

    // Schedule state.
    logic [OPIDX_W-1:0]  op_counter_reg;
    logic [MAX_RANKS-1:0] ready_valid_reg;
    logic [OPIDX_W-1:0]  ready_op_reg [MAX_RANKS];

    // Per-request working registers.
    logic                phase_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [1:0]          err_reg;
    logic [RANKS_W-1:0]  send_owner_reg;
    logic [RANKS_W-1:0]  recv_owner_reg;
    logic [1:0]          shift_reg;
    logic [BYTES_W-1:0]  ssize_reg;
    logic [BYTES_W-1:0]  soff_reg;
    logic [BYTES_W-1:0]  rsize_reg;
    logic [BYTES_W-1:0]  roff_reg;
    logic [OPIDX_W-1:0]  ridx_reg;

    // Output register.
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [1:0]          op_kind_reg;
    logic [OPIDX_W-1:0]  op_index_reg;
    logic [BYTES_W-1:0]  byte_count_reg;
    logic [BYTES_W-1:0]  byte_offset_reg;
    logic [RANK_W-1:0]   peer_rank_reg;
    logic                dep_valid_reg;
    logic [OPIDX_W-1:0]  dep_index_reg;
    logic [PAIR_W-1:0]   pair_id_reg;
    logic                last_reg;

    // Divider hookup.
    logic                div_start;
    logic                div_busy;
    logic [BYTES_W-1:0]  div_quo;
    logic [RANKS_W-1:0]  div_rem;

    logic                cfg_ok;
    logic                step_bad;
    logic [1:0]          shift_amt;
    logic [BYTES_W-1:0]  elem_mask;
    logic [RANKS_W-1:0]  send_owner_c;
    logic [RANKS_W-1:0]  recv_owner_c;
    logic [RANK_W-1:0]   next_peer;
    logic [RANK_W-1:0]   prev_peer;
    logic                slot_free;
    logic                emit;

    logic [RANKS_W-1:0]        mul_owner;
    logic [BYTES_W+RANKS_W-1:0] mul_prod;
    logic                      mul_inc;
    logic [RANKS_W-1:0]        mul_lo;
    logic [BYTES_W-1:0]        mul_size;
    logic [BYTES_W-1:0]        mul_off;

    logic [IDX_W-1:0]    send_sel;
    logic [IDX_W-1:0]    recv_sel;

    // Reduce a value known to lie in [nr+1, 3nr] modulo nr with up to three
    // subtracts; the top of the range needs all three.
    function automatic logic [RANKS_W-1:0] ring_mod(
        input logic [RANKS_W+1:0] val,
        input logic [RANKS_W-1:0] nr
    );
        logic [RANKS_W+1:0] t;
        begin
            t = val - {2'b00, nr};
            if (t >= {2'b00, nr})
            begin
                t = t - {2'b00, nr};
            end
            if (t >= {2'b00, nr})
            begin
                t = t - {2'b00, nr};
            end
            return t[RANKS_W-1:0];
        end
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    // A result slot loads the output register in this cycle.
    assign emit = slot_free && (state_reg inside {S_PUT, S_RECV, S_REDUCE, S_ERR});

    // Element size is a power of two, so scaling by it is a shift.
    always_comb
    begin
        case (element_bytes_reg)
            4'd2:    shift_amt = 2'd1;
            4'd4:    shift_amt = 2'd2;
            4'd8:    shift_amt = 2'd3;
            default: shift_amt = 2'd0;
        endcase
    end

    assign elem_mask = BYTES_W'(element_bytes_reg) - 1'b1;

    assign cfg_ok = (rank_count_reg >= 5'd2)
                 && (32'(rank_count_reg) <= MAX_RANKS)
                 && ({1'b0, own_rank_reg} < rank_count_reg)
                 && ((element_bytes_reg == 4'd1) || (element_bytes_reg == 4'd2)
                     || (element_bytes_reg == 4'd4) || (element_bytes_reg == 4'd8))
                 && (tensor_bytes_reg != '0)
                 && ((tensor_bytes_reg & elem_mask) == '0);

    assign step_bad = ({1'b0, step_reg} >= (rank_count_reg - 5'd1));

    // Shard owners: reduce-scatter sends own-step and receives own-step-1;
    // all-gather is shifted forward by one.
    always_comb
    begin
        logic [RANKS_W+1:0] base_t;
        base_t = {3'b000, own_rank_reg} + {1'b0, rank_count_reg, 1'b0}
               - {3'b000, step_reg};
        if (phase_reg)
        begin
            send_owner_c = ring_mod(base_t + 7'd1, rank_count_reg);
            recv_owner_c = ring_mod(base_t, rank_count_reg);
        end
        else
        begin
            send_owner_c = ring_mod(base_t, rank_count_reg);
            recv_owner_c = ring_mod(base_t - 7'd1, rank_count_reg);
        end
    end

    assign next_peer = ({1'b0, own_rank_reg} + 5'd1 == rank_count_reg)
                     ? '0 : own_rank_reg + 4'd1;
    assign prev_peer = (own_rank_reg == '0)
                     ? RANK_W'(rank_count_reg - 5'd1) : own_rank_reg - 4'd1;

    // Shared multiply: owner times base elements, then scale to bytes.
    assign mul_owner = (state_reg == S_MUL_SEND) ? send_owner_reg : recv_owner_reg;
    assign mul_prod  = mul_owner * div_quo;
    assign mul_inc   = (mul_owner < div_rem);
    assign mul_lo    = mul_inc ? mul_owner : div_rem;
    assign mul_size  = (div_quo + BYTES_W'(mul_inc)) << shift_reg;
    assign mul_off   = (mul_prod[BYTES_W-1:0] + BYTES_W'(mul_lo)) << shift_reg;

    assign div_start = (state_reg == S_CHECK) && cfg_ok && !step_bad;

    assign send_sel = IDX_W'(send_owner_reg);
    assign recv_sel = IDX_W'(recv_owner_reg);

    rar_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (tensor_bytes_reg >> shift_amt),
        .divisor   (rank_count_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_count_reg    <= RANK_COUNT_RST;
            own_rank_reg      <= '0;
            tensor_bytes_reg  <= '0;
            element_bytes_reg <= ELEMENT_BYTES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANK_COUNT:    rank_count_reg    <= cfg_data[RANKS_W-1:0];
                REG_OWN_RANK:      own_rank_reg      <= cfg_data[RANK_W-1:0];
                REG_TENSOR_BYTES:  tensor_bytes_reg  <= cfg_data;
                REG_ELEMENT_BYTES: element_bytes_reg <= cfg_data[EBYTES_W-1:0];
                default:           ;
            endcase
        end
    end

    // Readiness table payload: written when a receive completes a shard.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RECV && slot_free && phase_reg)
        begin
            ready_op_reg[recv_sel] <= op_counter_reg;
        end
        else if (state_reg == S_REDUCE && slot_free)
        begin
            ready_op_reg[recv_sel] <= op_counter_reg;
        end
    end

    // Sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_counter_reg  <= '0;
            ready_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        phase_reg <= phase;
                        step_reg  <= step_num;
                        if (restart)
                        begin
                            op_counter_reg  <= '0;
                            ready_valid_reg <= '0;
                        end
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    send_owner_reg <= send_owner_c;
                    recv_owner_reg <= recv_owner_c;
                    shift_reg      <= shift_amt;
                    if (!cfg_ok)
                    begin
                        err_reg   <= STATUS_BAD_CFG;
                        state_reg <= S_ERR;
                    end
                    else if (step_bad)
                    begin
                        err_reg   <= STATUS_BAD_STEP;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        state_reg <= S_DIV_WAIT;
                    end
                end

                S_DIV_WAIT:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_MUL_SEND;
                    end
                end

                S_MUL_SEND:
                begin
                    ssize_reg <= mul_size;
                    soff_reg  <= mul_off;
                    state_reg <= S_MUL_RECV;
                end

                S_MUL_RECV:
                begin
                    rsize_reg <= mul_size;
                    roff_reg  <= mul_off;
                    if (ssize_reg != '0)
                    begin
                        state_reg <= S_PUT;
                    end
                    else if (mul_size != '0)
                    begin
                        state_reg <= S_RECV;
                    end
                    else
                    begin
                        // Both shards are empty: the request yields nothing.
                        state_reg <= S_IDLE;
                    end
                end

                S_PUT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= STATUS_OK;
                        op_kind_reg     <= OP_PUT;
                        op_index_reg    <= op_counter_reg;
                        byte_count_reg  <= ssize_reg;
                        byte_offset_reg <= soff_reg;
                        peer_rank_reg   <= next_peer;
                        dep_valid_reg   <= ready_valid_reg[send_sel];
                        dep_index_reg   <= ready_valid_reg[send_sel]
                                         ? ready_op_reg[send_sel] : '0;
                        pair_id_reg     <= PAIR_W'({send_owner_reg, phase_reg});
                        last_reg        <= (rsize_reg == '0);
                        op_counter_reg  <= op_counter_reg + 1'b1;
                        state_reg       <= (rsize_reg == '0) ? S_IDLE : S_RECV;
                    end
                end

                S_RECV:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= STATUS_OK;
                        op_kind_reg     <= OP_RECV;
                        op_index_reg    <= op_counter_reg;
                        byte_count_reg  <= rsize_reg;
                        byte_offset_reg <= roff_reg;
                        peer_rank_reg   <= prev_peer;
                        dep_valid_reg   <= 1'b0;
                        dep_index_reg   <= '0;
                        pair_id_reg     <= PAIR_W'({recv_owner_reg, phase_reg});
                        last_reg        <= phase_reg;
                        ridx_reg        <= op_counter_reg;
                        op_counter_reg  <= op_counter_reg + 1'b1;
                        if (phase_reg)
                        begin
                            ready_valid_reg[recv_sel] <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_REDUCE;
                        end
                    end
                end

                S_REDUCE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= STATUS_OK;
                        op_kind_reg     <= OP_RECV_REDUCE;
                        op_index_reg    <= op_counter_reg;
                        byte_count_reg  <= rsize_reg;
                        byte_offset_reg <= roff_reg;
                        peer_rank_reg   <= '0;
                        dep_valid_reg   <= 1'b1;
                        dep_index_reg   <= ridx_reg;
                        pair_id_reg     <= '0;
                        last_reg        <= 1'b1;
                        op_counter_reg  <= op_counter_reg + 1'b1;
                        ready_valid_reg[recv_sel] <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end

                S_ERR:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= err_reg;
                        op_kind_reg     <= OP_PUT;
                        op_index_reg    <= '0;
                        byte_count_reg  <= '0;
                        byte_offset_reg <= '0;
                        peer_rank_reg   <= '0;
                        dep_valid_reg   <= 1'b0;
                        dep_index_reg   <= '0;
                        pair_id_reg     <= '0;
                        last_reg        <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign op_kind     = op_kind_reg;
    assign op_index    = op_index_reg;
    assign byte_count  = byte_count_reg;
    assign byte_offset = byte_offset_reg;
    assign peer_rank   = peer_rank_reg;
    assign dep_valid   = dep_valid_reg;
    assign dep_index   = dep_index_reg;
    assign pair_id     = pair_id_reg;
    assign last        = last_reg;
endmodule
